@@ hdl/msfq_pkg.sv @@
package msfq_pkg;

  localparam int TIME_W          = 48;
  localparam int SVC_W           = 32;
  localparam int SUM_W           = 64;
  localparam int COUNT_W         = 32;
  localparam int CFG_W           = 5;
  localparam int DEF_MAX_SERVERS = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(1);
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [SVC_W-1:0]  service_dur;
    logic              last_request;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  mean_stay_time;
    logic [COUNT_W-1:0] request_count;
    logic               sum_saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SLAST,
    ST_CALC,
    ST_UPD1,
    ST_UPD2,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

@@ hdl/multi_server_fcfs_queue_sim.sv @@
// Multi-server first-come-first-served queue simulator. Each input transaction
// is one request (arrival time Q32.16, service time Q16.16, last flag). The
// block scans the server free-time memory for the earliest free active server
// (lowest index on a tie), charges the wait, books the server until arrival +
// wait + service (saturating at the 48-bit maximum) and adds wait + service to
// a saturating 64-bit stay sum. After a request is accepted, in_stall_o stays
// high through the SCAN, SLAST, CALC, UPD1 and UPD2 states. With n the number
// of active servers (servers_in_use clamped to 1..MAX_SERVERS), SCAN reads the
// n free-time entries one at a time through the single memory read port,
// SLAST compares the last entry read, then CALC, UPD1 and UPD2 update the
// server and the sums. The next request is taken in the idle state after
// that. For the request marked last, UPD2 starts the divider through a
// register, the divider divides the stay sum by the count bit-serially and
// registers its finish, and the output register is loaded once the previous
// result has been taken. One output transaction per series carries mean stay
// time, request count and a flag that the sum or the count saturated; then all
// series state is cleared. in_stall_o is low only while the block is idle.
// servers_in_use is written through cfg_we_i / cfg_data_i and keeps its value
// across series. The user must write it only while idle; the block does not enforce this.
module multi_server_fcfs_queue_sim
  import msfq_pkg::*;
#(
  parameter int MAX_SERVERS = DEF_MAX_SERVERS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NUM_W = $clog2(MAX_SERVERS + 1);

  state_e state_q, state_d;

  // configuration
  logic [CFG_W-1:0] servers_q;
  logic [NUM_W-1:0] n_act;
  logic [NUM_W-1:0] n_m1;
  logic [IDX_W-1:0] last_idx;

  // request being worked on
  logic [TIME_W-1:0] arr_q;
  logic [SVC_W-1:0]  svc_q;
  logic              last_q;

  // free-time memory, valid bits stand for the all-zero reset and clear
  logic [TIME_W-1:0]      free_mem_q [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_q;
  logic [IDX_W-1:0]       rd_addr;
  logic [TIME_W-1:0]      rd_data_q;
  logic                   rd_vld_q;
  logic [TIME_W-1:0]      rd_free;

  // scan
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              have_q;
  logic [TIME_W-1:0] best_q;
  logic [IDX_W-1:0]  pick_q;
  logic              cmp_en;

  // update datapath
  logic [TIME_W-1:0]  start_q;
  logic [TIME_W-1:0]  wait_q;
  logic [TIME_W:0]    stay_q;
  logic [TIME_W:0]    done_sum;
  logic [TIME_W-1:0]  done_sat;
  logic [SUM_W:0]     sum_nx;
  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               sat_q;

  // control from the sequencer
  logic in_stall;
  logic mem_we;
  logic div_start;
  logic div_go_q;
  logic out_load;
  logic out_free;

  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [TIME_W-1:0] mean;

  out_item_t out_q;
  logic      out_valid_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servers_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      servers_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (servers_q == '0) begin
      n_act = NUM_W'(1);
    end else if (32'(servers_q) > 32'(MAX_SERVERS)) begin
      n_act = NUM_W'(MAX_SERVERS);
    end else begin
      n_act = NUM_W'(servers_q);
    end
    n_m1     = NUM_W'(n_act - 1'b1);
    last_idx = n_m1[IDX_W-1:0];
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (idx_q == last_idx) state_d = ST_SLAST;
      ST_SLAST: state_d = ST_CALC;
      ST_CALC:  state_d = ST_UPD1;
      ST_UPD1:  state_d = ST_UPD2;
      ST_UPD2:  state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    rd_addr   = idx_q;
    cmp_en    = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  cmp_en = have_q;
      ST_SLAST: cmp_en = 1'b1;
      ST_UPD1:  mem_we = 1'b1;
      ST_UPD2:  div_start = last_q;
      ST_EMIT:  out_load = out_free;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      free_mem_q[pick_q] <= done_sat;
    end
    rd_data_q <= free_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (out_load) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[pick_q] <= 1'b1;
      end
    end
  end

  assign rd_free = rd_vld_q ? rd_data_q : '0;

  // ------------------------------------------------------- scan and update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      sum_q  <= '0;
      cnt_q  <= '0;
      sat_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        have_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        have_q <= 1'b1;
      end
      if (state_q == ST_UPD1) begin
        if (cnt_q == COUNT_MAX) begin
          sat_q <= 1'b1;
        end else begin
          cnt_q <= COUNT_W'(cnt_q + 1'b1);
        end
      end
      if (state_q == ST_UPD2) begin
        if (sum_nx[SUM_W]) begin
          sum_q <= SUM_MAX;
          sat_q <= 1'b1;
        end else begin
          sum_q <= sum_nx[SUM_W-1:0];
        end
      end
      if (out_load) begin
        sum_q <= '0;
        cnt_q <= '0;
        sat_q <= 1'b0;
      end
    end
  end

  assign done_sum = {1'b0, start_q} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_q};
  assign done_sat = done_sum[TIME_W] ? TIME_MAX : done_sum[TIME_W-1:0];
  assign sum_nx   = {1'b0, sum_q} + {{(SUM_W - TIME_W){1'b0}}, stay_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      arr_q  <= in_data_i.arrival_time;
      svc_q  <= in_data_i.service_dur;
      last_q <= in_data_i.last_request;
      idx_q  <= '0;
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= idx_q;
      if (idx_q != last_idx) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
      end
    end
    // strict less-than keeps the lowest index on a tie
    if (cmp_en && (cmp_idx_q == '0 || rd_free < best_q)) begin
      best_q <= rd_free;
      pick_q <= cmp_idx_q;
    end
    if (state_q == ST_CALC) begin
      if (best_q > arr_q) begin
        start_q <= best_q;
        wait_q  <= best_q - arr_q;
      end else begin
        start_q <= arr_q;
        wait_q  <= '0;
      end
    end
    if (state_q == ST_UPD1) begin
      stay_q <= {1'b0, wait_q} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_q};
    end
  end

  // ---------------------------------------------------------------- divide
  // start from a register so the divider loads the sum with the last stay added
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= div_start;
    end
  end

  msfq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign mean = (|div_quo[SUM_W-1:TIME_W]) ? TIME_MAX : div_quo[TIME_W-1:0];

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.mean_stay_time <= mean;
      out_q.request_count  <= cnt_q;
      out_q.sum_saturated  <= sat_q;
    end
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------ assertions
  a_acc_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit step");

  a_free_not_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD1 |-> done_sat >= arr_q)
    else $error("new free time earlier than arrival");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> cnt_q != '0)
    else $error("divide started with zero count");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> pick_q <= last_idx)
    else $error("picked server outside the active set");

endmodule

@@ hdl/msfq_div.sv @@
module msfq_div
  import msfq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  logic [COUNT_W-1:0] divisor_i,
  output logic               done_o,
  output logic [SUM_W-1:0]   quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] dvs_q;
  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= STEP_W'(step_q + 1'b1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import msfq_pkg::*;

  // An initial block fills a queue of request transactions, phase by phase,
  // each phase under its own servers_in_use setting. A clocked driver feeds
  // them to the block, and a clocked monitor takes the series reports. A
  // predictor computes the expected report for every accepted request that
  // closes a series.

  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  // One 16-server request plus the divide and the handover, with margin.
  localparam int unsigned SETTLE_CYCLES    = 120;
  localparam int unsigned MAX_GAP          = 13;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned RANDOM_PHASES    = 10;
  localparam int unsigned PHASE_REQUESTS   = 85;

  typedef struct {
    in_item_t    req;
    int unsigned gap_before;   // idle cycles ahead of this transaction
    bit          drain_first;  // hold until every pending report is in
  } queued_req_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_data_i  = CFG_RESET;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  multi_server_fcfs_queue_sim DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: server free times, stay sum, count and saturation flag.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   model_servers = CFG_RESET;
  logic [TIME_W-1:0]  model_free_at [DEF_MAX_SERVERS];
  logic [SUM_W-1:0]   model_stay_sum;
  logic [COUNT_W-1:0] model_count;
  logic               model_sat;

  queued_req_t request_q[$];         // transactions not yet driven
  out_item_t   series_reports_q[$];  // reports due from the block, oldest first

  int unsigned mismatch_cnt = 0;
  bit          calm_fill    = 1'b0;  // stretch of back-to-back requests

  function automatic void clear_model_series();
    foreach (model_free_at[i]) model_free_at[i] = '0;
    model_stay_sum = '0;
    model_count    = '0;
    model_sat      = 1'b0;
  endfunction

  // Book one accepted request; a request closing the series yields a report.
  function automatic void serve_request(in_item_t req);
    int unsigned       active;
    int unsigned       pick;
    int unsigned       s;
    logic [TIME_W-1:0] wait_t;
    logic [63:0]       done_t;
    logic [SUM_W-1:0]  stay_t;
    logic [SUM_W-1:0]  mean_t;
    out_item_t         report;
    // 0 acts as one server, anything above the array size as all of them
    active = model_servers;
    if (active < 1) active = 1;
    if (active > DEF_MAX_SERVERS) active = DEF_MAX_SERVERS;
    // strict compare keeps the lowest index on a tie
    pick = 0;
    for (s = 1; s < active; s++)
      if (model_free_at[s] < model_free_at[pick]) pick = s;
    wait_t = (model_free_at[pick] > req.arrival_time) ?
             model_free_at[pick] - req.arrival_time : '0;
    done_t = 64'(req.arrival_time) + 64'(wait_t) + 64'(req.service_dur);
    if (done_t > 64'(TIME_MAX)) done_t = 64'(TIME_MAX);
    model_free_at[pick] = done_t[TIME_W-1:0];
    stay_t = 64'(wait_t) + 64'(req.service_dur);
    if (model_stay_sum > SUM_MAX - stay_t) begin
      model_stay_sum = SUM_MAX;
      model_sat      = 1'b1;
    end else begin
      model_stay_sum = model_stay_sum + stay_t;
    end
    if (model_count == COUNT_MAX) begin
      model_sat = 1'b1;
    end else begin
      model_count = model_count + 1'b1;
    end
    if (req.last_request) begin
      mean_t = model_stay_sum / 64'(model_count);
      if (mean_t > 64'(TIME_MAX)) mean_t = 64'(TIME_MAX);
      report.mean_stay_time = mean_t[TIME_W-1:0];
      report.request_count  = model_count;
      report.sum_saturated  = model_sat;
      series_reports_q.insert(series_reports_q.size(), report);
      clear_model_series();
    end
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void queue_request(logic [TIME_W-1:0] arrival,
                                        logic [SVC_W-1:0] service,
                                        bit last, bit drain = 1'b0);
    queued_req_t q;
    if ($urandom_range(0, 39) == 0) calm_fill = !calm_fill;
    q.req.arrival_time = arrival;
    q.req.service_dur  = service;
    q.req.last_request = last;
    q.gap_before       = draw_gap(calm_fill);
    q.drain_first      = drain;
    request_q.insert(request_q.size(), q);
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Mostly well-formed series (nondecreasing arrivals, services that make
  // requests queue up), with some full-range and out-of-order noise mixed in.
  function automatic void queue_random_series(int unsigned len);
    logic [TIME_W-1:0] arrival;
    logic [SVC_W-1:0]  service;
    int unsigned       k;
    case ($urandom_range(0, 4))
      0:       arrival = any_time();
      1:       arrival = TIME_MAX - TIME_W'($urandom_range(0, 1 << 22));
      default: arrival = TIME_W'($urandom_range(0, 1 << 20));
    endcase
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          arrival = any_time();
          service = $urandom;
        end
        1: service = '0;  // simultaneous, zero-length request
        2: begin
          arrival = arrival + TIME_W'($urandom);
          service = $urandom;
        end
        default: begin
          arrival = arrival + TIME_W'($urandom_range(0, 3 << 16));
          service = SVC_W'($urandom_range(0, 12 << 16));
        end
      endcase
      queue_request(arrival, service, k == len - 1, $urandom_range(0, 49) == 0);
    end
  endfunction

  // Settings change only while idle.
  task automatic write_servers(logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    model_servers = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for all queued transactions and reports, then let the block settle.
  task automatic drain_block();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || series_reports_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one request transaction at a time, gaps taken from the queue.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) serve_request(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && idle_cycles >= request_q[0].gap_before &&
            !(request_q[0].drain_first && series_reports_q.size() != 0)) begin
          in_data_i   <= request_q[0].req;
          in_valid_i  <= 1'b1;
          idle_cycles = 0;
          void'(request_q.pop_front());
        end else begin
          in_valid_i  <= 1'b0;
          idle_cycles = idle_cycles + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall per report, compare against oldest expectation.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          calm_recv  = 1'b0;

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (series_reports_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOWN_MISMATCHES)
            $display("unexpected report: mean %h count %0d sat %b",
                     out_data_o.mean_stay_time, out_data_o.request_count,
                     out_data_o.sum_saturated);
        end else begin
          want = series_reports_q.pop_front();
          if (want.mean_stay_time !== out_data_o.mean_stay_time ||
              want.request_count  !== out_data_o.request_count  ||
              want.sum_saturated  !== out_data_o.sum_saturated) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOWN_MISMATCHES)
              $display("report mismatch: mean %h/%h count %0d/%0d sat %b/%b (exp/act)",
                       want.mean_stay_time, out_data_o.mean_stay_time,
                       want.request_count, out_data_o.request_count,
                       want.sum_saturated, out_data_o.sum_saturated);
          end
        end
        if ($urandom_range(0, 29) == 0) calm_recv = !calm_recv;
        stall_left = draw_gap(calm_recv);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] phase_servers [RANDOM_PHASES];
    int unsigned      p;
    int unsigned      queued;
    int unsigned      len;

    phase_servers = '{5'd1, 5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd5, 5'd0};
    phase_servers[RANDOM_PHASES-1] = $urandom_range(0, 31);
    clear_model_series();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: lone zero request, free time ceiling, then an arrival far
    // below the booked free time (maximal wait).
    queue_request('0, '0, 1'b1);
    queue_request(TIME_MAX, '1, 1'b0);
    queue_request('0, '1, 1'b1);
    drain_block();

    // Zero acts as one server: second request queues behind the first.
    write_servers(5'd0);
    queue_request(TIME_W'(100 << 16), SVC_W'(5 << 16), 1'b0);
    queue_request(TIME_W'(100 << 16), SVC_W'(5 << 16), 1'b0);
    queue_request(TIME_W'(101 << 16), '0, 1'b1);
    drain_block();

    // Out-of-range count acts as all servers.
    write_servers(5'd31);
    queue_request('0, '1, 1'b0);
    queue_request('0, '1, 1'b0);
    queue_request(TIME_W'(5), SVC_W'(1), 1'b1);
    drain_block();

    // Four servers: ties go to the lowest index, fifth and sixth wait.
    write_servers(5'd4);
    queue_request(TIME_W'(1 << 16), SVC_W'(3 << 16), 1'b0);
    queue_request(TIME_W'(1 << 16), SVC_W'(1 << 16), 1'b0);
    queue_request(TIME_W'(1 << 16), SVC_W'(2 << 16), 1'b0);
    queue_request(TIME_W'(1 << 16), SVC_W'(4 << 16), 1'b0);
    queue_request(TIME_W'(1 << 16), SVC_W'(1 << 16), 1'b0);
    queue_request(TIME_W'(1 << 16), SVC_W'(1 << 16), 1'b1);
    drain_block();

    // Full server set, all upper bits toggling.
    write_servers(5'd16);
    queue_request(TIME_MAX - TIME_W'(3), SVC_W'(2), 1'b0);
    queue_request(TIME_W'(48'h5555_5555_5555), SVC_W'(32'hAAAA_AAAA), 1'b0);
    queue_request(TIME_W'(48'hAAAA_AAAA_AAAA), SVC_W'(32'h5555_5555), 1'b1);
    drain_block();

    // Random phases, each closed by a series end so the block is idle after.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_servers(phase_servers[p]);
      queued = 0;
      while (queued < PHASE_REQUESTS) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        queue_random_series(len);
        queued += len;
      end
      drain_block();
    end

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
